### rtl/core/elc_pkg.sv
// elc_pkg: shared types and constants for the eps line ending converter
// holds the input and result word structs, the queue record and the byte codes
// no dependencies
package elc_pkg;

  localparam int POS_W       = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_BURST   = 4;
  localparam int BCNT_W      = $clog2(MAX_BURST + 1);
  localparam int BIDX_W      = $clog2(MAX_BURST);

  // status codes
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_TIFF  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  // byte codes
  localparam logic [7:0] CH_E_HI = 8'hC5;
  localparam logic [7:0] CH_P_HI = 8'hD0;
  localparam logic [7:0] CH_S_HI = 8'hD3;
  localparam logic [7:0] CH_F_HI = 8'hC6;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_M    = 8'h4D;

  // header positions
  localparam logic [POS_W-1:0] POS_START_DONE = POS_W'(7);
  localparam logic [POS_W-1:0] POS_LEN_DONE   = POS_W'(11);
  localparam logic [POS_W-1:0] POS_HDR_END    = POS_W'(27);
  localparam logic [POS_W-1:0] POS_THIRD      = POS_W'(2);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       out_last;
  } out_item_t;

  // one burst of result words; only the final word carries status and last
  typedef struct packed {
    logic [BCNT_W-1:0]          cnt;
    logic [MAX_BURST-1:0][7:0]  bytes;
    logic [1:0]                 st;
    logic                       lst;
  } burst_t;

  typedef struct packed {
    logic   push;
    burst_t burst;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/core/elc_front.sv
// elc_front: accepts input words, tracks the file layout and builds result bursts
// depends on elc_pkg
module elc_front import elc_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  input  logic     q_full,
  output q_wr_t    q_wr
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_MAGIC,
    PH_HEADER,
    PH_BODY,
    PH_WHOLE,
    PH_DISCARD
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] len_r, len_nxt;
  logic [31:0]            hw_r, hw_nxt;
  logic                   pend_r, pend_nxt;
  logic [2:0][7:0]        held_r;

  logic             acc;
  logic [7:0]       b;
  logic             lastb;
  logic [31:0]      hw_shift;
  logic [POS_W-1:0] start_ext;
  logic [POS_W-1:0] len_ext;
  logic [POS_W-1:0] rel;
  logic             insec;
  logic             is_epsf;
  burst_t           burst;

  assign acc       = in_valid && !q_full;
  assign b         = in_data.in_byte;
  assign lastb     = in_data.in_last;
  assign hw_shift  = {b, hw_r[31:8]};
  assign start_ext = POS_W'(start_r);
  assign len_ext   = POS_W'(len_r);
  assign rel       = pos_r - start_ext;
  assign is_epsf   = (held_r[0] == CH_E_HI) && (held_r[1] == CH_P_HI) &&
                     (held_r[2] == CH_S_HI) && (b == CH_F_HI);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = (pos_r == {POS_W{1'b1}}) ? pos_r : pos_r + POS_W'(1);
    start_nxt = start_r;
    len_nxt   = len_r;
    hw_nxt    = hw_r;
    pend_nxt  = pend_r;
    insec     = 1'b0;
    burst     = '0;
    burst.st  = ST_DATA;

    case (phase_r)
      PH_FIRST: begin
        if (lastb) begin
          burst.cnt = BCNT_W'(1);
          burst.st  = ST_BAD;
          burst.lst = 1'b1;
        end else begin
          phase_nxt = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if ((held_r[0] == CH_I && b == CH_I) || (held_r[0] == CH_M && b == CH_M)) begin
          burst.cnt = BCNT_W'(1);
          burst.st  = ST_TIFF;
          burst.lst = 1'b1;
          phase_nxt = PH_DISCARD;
        end else if (held_r[0] == CH_PCT && b == CH_BANG) begin
          burst.cnt      = BCNT_W'(2);
          burst.bytes[0] = held_r[0];
          burst.bytes[1] = b;
          burst.lst      = lastb;
          phase_nxt      = PH_WHOLE;
        end else if (lastb) begin
          burst.cnt = BCNT_W'(1);
          burst.st  = ST_BAD;
          burst.lst = 1'b1;
        end else begin
          phase_nxt = PH_MAGIC;
        end
      end
      PH_MAGIC: begin
        if (pos_r == POS_THIRD) begin
          if (lastb) begin
            burst.cnt = BCNT_W'(1);
            burst.st  = ST_BAD;
            burst.lst = 1'b1;
          end
        end else if (is_epsf) begin
          if (lastb) begin
            burst.cnt = BCNT_W'(1);
            burst.st  = ST_TRUNC;
            burst.lst = 1'b1;
          end else begin
            burst.cnt      = BCNT_W'(4);
            burst.bytes[0] = held_r[0];
            burst.bytes[1] = held_r[1];
            burst.bytes[2] = held_r[2];
            burst.bytes[3] = b;
            phase_nxt      = PH_HEADER;
          end
        end else begin
          burst.cnt = BCNT_W'(1);
          burst.st  = ST_BAD;
          burst.lst = 1'b1;
          phase_nxt = PH_DISCARD;
        end
      end
      PH_HEADER: begin
        hw_nxt = hw_shift;
        if (pos_r == POS_START_DONE) start_nxt = hw_shift[OFFSET_BITS-1:0];
        if (pos_r == POS_LEN_DONE) len_nxt = hw_shift[OFFSET_BITS-1:0];
        burst.cnt = BCNT_W'(1);
        if (pos_r >= POS_HDR_END) begin
          burst.bytes[0] = b;
          burst.lst      = lastb;
          phase_nxt      = PH_BODY;
        end else if (lastb) begin
          burst.st  = ST_TRUNC;
          burst.lst = 1'b1;
        end else begin
          burst.bytes[0] = b;
        end
      end
      PH_BODY, PH_WHOLE: begin
        insec = (phase_r == PH_WHOLE) || ((pos_r >= start_ext) && (rel < len_ext));
        // a held CR leaves first, as CR only when LF follows
        if (pend_r) begin
          burst.bytes[0] = (b == CH_LF) ? CH_CR : CH_LF;
          burst.cnt      = BCNT_W'(1);
          pend_nxt       = 1'b0;
        end
        if (insec && b == CH_CR) begin
          if (lastb) begin
            burst.bytes[BIDX_W'(pend_r)] = CH_LF;
            burst.lst                    = 1'b1;
            burst.cnt                    = burst.cnt + BCNT_W'(1);
          end else begin
            pend_nxt = 1'b1;
          end
        end else begin
          burst.bytes[BIDX_W'(pend_r)] = b;
          burst.lst                    = lastb;
          burst.cnt                    = burst.cnt + BCNT_W'(1);
        end
      end
      PH_DISCARD: begin
      end
      default: begin
        phase_nxt = PH_FIRST;
      end
    endcase

    // end of file or an illegal phase: back to a clean start
    if (lastb || phase_r > PH_DISCARD) begin
      phase_nxt = PH_FIRST;
      pos_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
      hw_nxt    = '0;
      pend_nxt  = 1'b0;
    end
  end

  assign q_wr.push  = acc && (burst.cnt != '0);
  assign q_wr.burst = burst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      hw_r    <= '0;
      pend_r  <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      hw_r    <= hw_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // first three bytes of the file
  always_ff @(posedge clk) begin
    if (acc) begin
      if (phase_r == PH_FIRST) held_r[0] <= b;
      if (phase_r == PH_SECOND) held_r[1] <= b;
      if (phase_r == PH_MAGIC && pos_r == POS_THIRD) held_r[2] <= b;
    end
  end

  a_pend_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (phase_r == PH_BODY || phase_r == PH_WHOLE))
    else $error("held CR outside the body phases");

endmodule

### rtl/core/elc_queue.sv
// elc_queue: short queue of result bursts between front and back
// depends on elc_pkg
module elc_queue import elc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_wr_t   q_wr,
  input  logic    pop,
  output burst_t  head,
  output q_stat_t stat
);

  burst_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (q_wr.push && !stat.full) mem_r[wr_ptr_r] <= q_wr.burst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_wr.push && !stat.full) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({q_wr.push && !stat.full, do_pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && stat.full))
    else $error("burst pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("pop from an empty queue");

endmodule

### rtl/core/elc_back.sv
// elc_back: walks the head burst one word a cycle, while out_stall is low, into the output register
// depends on elc_pkg
module elc_back import elc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  burst_t    head,
  input  q_stat_t   stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic              out_valid_r;
  out_item_t         out_data_r, word;
  logic [BIDX_W-1:0] idx_r;
  logic              fin;
  logic              load;

  assign fin  = (BCNT_W'(idx_r) + BCNT_W'(1)) == head.cnt;
  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !stat.empty && fin;

  always_comb begin
    word.out_byte = head.bytes[idx_r];
    word.status   = fin ? head.st : ST_DATA;
    word.out_last = fin && head.lst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= !stat.empty;
      if (!stat.empty) idx_r <= fin ? '0 : idx_r + BIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && !stat.empty) out_data_r <= word;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.empty |-> (BCNT_W'(idx_r) < head.cnt))
    else $error("word index beyond burst length");

  a_status_ends_file: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_DATA) |-> out_data.out_last)
    else $error("reject status word without last mark");

endmodule

### rtl/core/eps_line_ending_converter.sv
// eps_line_ending_converter: top level, front classifier, burst queue and word sender
// depends on elc_pkg, elc_front, elc_queue, elc_back
//
// Use: a file streams in one byte a word on the in_ channel, its final byte
// marked by in_last. Results leave on the out_ channel as out_byte, status and
// out_last. PostScript files ("%!") pass whole with lone CR turned into LF;
// binary EPSF headers pass raw and only the section they name is converted.
// TIFF or unknown starts give one word with a reject status and out_last set.
// A result word reaches the outputs through the burst queue and then the output
// register. An input word is taken every cycle while the queue of four bursts
// has room; the sender drains one result word a cycle while out_stall is low,
// so the rate is set by the output port, with the four-word EPSF magic burst
// and the two-word CR bursts absorbed by the queue.
// in_stall rises only when the queue is full. When out_stall is high the
// output register holds its word and the queue fills behind it.
// Reset clears the file state, the queue and the output valid; no words are
// lost or repeated across a stall on either side.
module eps_line_ending_converter import elc_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  q_wr_t   q_wr;
  q_stat_t q_stat;
  burst_t  q_head;
  logic    q_pop;

  assign in_stall = q_stat.full;

  elc_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_stat.full),
    .q_wr     (q_wr)
  );

  elc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  elc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .stat      (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### dv/eps_line_ending_converter_test.sv
`timescale 1ns / 1ps
// eps_line_ending_converter_test: self-checking bench for the eps line ending converter
// depends on elc_pkg and eps_line_ending_converter; builds files, predicts every result word
module eps_line_ending_converter_test;
  import elc_pkg::*;

  localparam int OFFSET_BITS = 32;
  localparam logic [31:0] SECTION_MASK =
    (OFFSET_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << OFFSET_BITS) - 32'd1);
  localparam int RANDOM_WORDS = 430;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [2:0] {
    FP_FIRST, FP_SECOND, FP_MAGIC, FP_HEADER, FP_BODY, FP_WHOLE, FP_DISCARD
  } file_phase_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // pending input words, expected result words, file under construction
  in_item_t   byte_q[$];
  out_item_t  want_q[$];
  logic [7:0] file_buf[$];

  // predictor state for the file in flight
  file_phase_t fphase = FP_FIRST;
  logic [31:0] file_pos = '0;
  logic [7:0]  magic_bytes[3] = '{8'h00, 8'h00, 8'h00};
  logic [31:0] sec_start = '0;
  logic [31:0] sec_len = '0;
  logic [31:0] hdr_word = '0;
  logic        cr_held = 1'b0;

  int total_words = 0;
  int words_taken = 0;
  int counted = 0;
  int files_built = 0;
  int results_checked = 0;
  int errors = 0;
  int tiff_seen = 0;
  int bad_seen = 0;
  int trunc_seen = 0;
  int cycle_cnt = 0;

  eps_line_ending_converter #(.OFFSET_BITS(OFFSET_BITS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_result(logic [7:0] b, logic [1:0] st, logic fin);
    out_item_t w;
    w.out_byte = b;
    w.status = st;
    w.out_last = fin;
    want_q.push_back(w);
  endfunction

  function automatic void restart_file();
    fphase = FP_FIRST;
    file_pos = '0;
    sec_start = '0;
    sec_len = '0;
    hdr_word = '0;
    cr_held = 1'b0;
  endfunction

  // works out the result words caused by one accepted input word
  function automatic void predict_word(in_item_t w);
    logic [31:0] p;
    logic [7:0]  b;
    logic        fin;
    logic        in_sec;
    p = file_pos;
    b = w.in_byte;
    fin = w.in_last;
    if (file_pos != 32'hFFFF_FFFF) file_pos = file_pos + 32'd1;
    case (fphase)
      FP_FIRST: begin
        magic_bytes[0] = b;
        if (fin) begin
          push_result(8'h00, ST_BAD, 1'b1);
          restart_file();
        end else begin
          fphase = FP_SECOND;
        end
      end
      FP_SECOND: begin
        magic_bytes[1] = b;
        if ((magic_bytes[0] == CH_I && b == CH_I) || (magic_bytes[0] == CH_M && b == CH_M)) begin
          push_result(8'h00, ST_TIFF, 1'b1);
          if (fin) restart_file();
          else fphase = FP_DISCARD;
        end else if (magic_bytes[0] == CH_PCT && b == CH_BANG) begin
          push_result(magic_bytes[0], ST_DATA, 1'b0);
          push_result(b, ST_DATA, fin);
          if (fin) restart_file();
          else fphase = FP_WHOLE;
        end else if (fin) begin
          push_result(8'h00, ST_BAD, 1'b1);
          restart_file();
        end else begin
          fphase = FP_MAGIC;
        end
      end
      FP_MAGIC: begin
        if (p == POS_THIRD) begin
          magic_bytes[2] = b;
          if (fin) begin
            push_result(8'h00, ST_BAD, 1'b1);
            restart_file();
          end
        end else if (magic_bytes[0] == CH_E_HI && magic_bytes[1] == CH_P_HI &&
                     magic_bytes[2] == CH_S_HI && b == CH_F_HI) begin
          if (fin) begin
            push_result(8'h00, ST_TRUNC, 1'b1);
            restart_file();
          end else begin
            push_result(magic_bytes[0], ST_DATA, 1'b0);
            push_result(magic_bytes[1], ST_DATA, 1'b0);
            push_result(magic_bytes[2], ST_DATA, 1'b0);
            push_result(b, ST_DATA, 1'b0);
            fphase = FP_HEADER;
          end
        end else begin
          push_result(8'h00, ST_BAD, 1'b1);
          if (fin) restart_file();
          else fphase = FP_DISCARD;
        end
      end
      FP_HEADER: begin
        // little-endian assembly, newest byte enters at the top
        hdr_word = {b, hdr_word[31:8]};
        if (p == POS_START_DONE) sec_start = hdr_word & SECTION_MASK;
        if (p == POS_LEN_DONE) sec_len = hdr_word & SECTION_MASK;
        if (p >= POS_HDR_END) begin
          push_result(b, ST_DATA, fin);
          if (fin) restart_file();
          else fphase = FP_BODY;
        end else if (fin) begin
          push_result(8'h00, ST_TRUNC, 1'b1);
          restart_file();
        end else begin
          push_result(b, ST_DATA, 1'b0);
        end
      end
      FP_BODY, FP_WHOLE: begin
        in_sec = (fphase == FP_WHOLE) || (p >= sec_start && (p - sec_start) < sec_len);
        // a held return is settled by whatever byte follows it
        if (cr_held) begin
          push_result((b == CH_LF) ? CH_CR : CH_LF, ST_DATA, 1'b0);
          cr_held = 1'b0;
        end
        if (in_sec && b == CH_CR) begin
          if (fin) push_result(CH_LF, ST_DATA, 1'b1);
          else cr_held = 1'b1;
        end else begin
          push_result(b, ST_DATA, fin);
        end
        if (fin) restart_file();
      end
      FP_DISCARD: begin
        if (fin) restart_file();
      end
      default: restart_file();
    endcase
  endfunction

  function automatic void check_word(out_item_t got);
    out_item_t want_w;
    if (got.status == ST_TIFF) tiff_seen++;
    if (got.status == ST_BAD) bad_seen++;
    if (got.status == ST_TRUNC) trunc_seen++;
    if (want_q.size() == 0) begin
      if (errors < 10)
        $display("unexpected word: byte %02h status %0d last %0d",
                 got.out_byte, got.status, got.out_last);
      errors++;
      return;
    end
    want_w = want_q.pop_front();
    results_checked++;
    if (got.out_byte !== want_w.out_byte || got.status !== want_w.status ||
        got.out_last !== want_w.out_last) begin
      if (errors < 10)
        $display("word %0d: expected byte %02h status %0d last %0d, got byte %02h status %0d last %0d",
                 results_checked, want_w.out_byte, want_w.status, want_w.out_last,
                 got.out_byte, got.status, got.out_last);
      errors++;
    end
  endfunction

  // idling phase follows progress through the stimulus
  function automatic int run_mode();
    int m;
    if (total_words == 0) return 0;
    m = (words_taken * 4) / total_words;
    return (m > 3) ? 3 : m;
  endfunction

  function automatic int send_idle_pct();
    case (run_mode())
      1: return 86;
      3: return 9;
      default: return 0;
    endcase
  endfunction

  function automatic int stall_pct();
    case (run_mode())
      2: return 86;
      3: return 9;
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] body_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return CH_CR;
    if (r < 40) return CH_LF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_magic();
    file_buf.push_back(CH_E_HI);
    file_buf.push_back(CH_P_HI);
    file_buf.push_back(CH_S_HI);
    file_buf.push_back(CH_F_HI);
  endfunction

  function automatic void add_word32(logic [31:0] v);
    file_buf.push_back(v[7:0]);
    file_buf.push_back(v[15:8]);
    file_buf.push_back(v[23:16]);
    file_buf.push_back(v[31:24]);
  endfunction

  // moves the built file into the input queue, last mark on its final byte
  function automatic void flush_file();
    in_item_t w;
    for (int i = 0; i < file_buf.size(); i++) begin
      w.in_byte = file_buf[i];
      w.in_last = (i == file_buf.size() - 1);
      byte_q.push_back(w);
    end
    file_buf.delete();
    files_built++;
  endfunction

  function automatic void add_random_file();
    int kind;
    int n;
    logic [31:0] s;
    logic [31:0] l;
    kind = $urandom_range(0, 99);
    if (kind < 34) begin
      file_buf.push_back(CH_PCT);
      file_buf.push_back(CH_BANG);
      n = $urandom_range(0, 18);
      repeat (n) file_buf.push_back(body_byte());
      counted += file_buf.size();
    end else if (kind < 70) begin
      add_magic();
      case ($urandom_range(0, 4))
        0: s = 32'd0;
        1: s = 32'd28;
        2: s = 32'($urandom_range(20, 44));
        3: s = $urandom();
        default: s = 32'($urandom_range(28, 34));
      endcase
      case ($urandom_range(0, 3))
        0: l = 32'd0;
        1: l = 32'hFFFF_FFFF;
        2: l = $urandom();
        default: l = 32'($urandom_range(1, 12));
      endcase
      add_word32(s);
      add_word32(l);
      // remaining header words, returns in them must pass raw
      repeat (16) file_buf.push_back(body_byte());
      n = $urandom_range(0, 22);
      repeat (n) file_buf.push_back(body_byte());
      counted += file_buf.size();
    end else if (kind < 78) begin
      add_magic();
      n = $urandom_range(4, 27);
      while (file_buf.size() < n) file_buf.push_back(body_byte());
      counted += file_buf.size();
    end else if (kind < 84) begin
      if ($urandom_range(0, 1) == 0) begin
        file_buf.push_back(CH_I);
        file_buf.push_back(CH_I);
      end else begin
        file_buf.push_back(CH_M);
        file_buf.push_back(CH_M);
      end
      n = $urandom_range(0, 3);
      repeat (n) file_buf.push_back(body_byte());
      counted += 2;
    end else if (kind < 92) begin
      if ($urandom_range(0, 1) == 0) begin
        add_magic();
        file_buf[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
      end else begin
        repeat (4) file_buf.push_back(8'($urandom_range(0, 255)));
      end
      n = $urandom_range(0, 2);
      repeat (n) file_buf.push_back(body_byte());
      counted += 4;
    end else begin
      n = $urandom_range(1, 3);
      if ($urandom_range(0, 1) == 0) file_buf.push_back(CH_PCT);
      while (file_buf.size() < n) file_buf.push_back(8'($urandom_range(0, 255)));
      counted += file_buf.size();
    end
    flush_file();
  endfunction

  // input side: holds a stalled word, otherwise loads the next or idles
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_word(in_data);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          in_data <= byte_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_word(out_data);
      out_stall <= ($urandom_range(0, 99) < stall_pct());
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_cnt, want_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // postscript: kept pair, lone return, return on the final byte
    file_buf = '{CH_PCT, CH_BANG, CH_CR, CH_LF, CH_CR, 8'h41, CH_CR};
    flush_file();
    file_buf = '{CH_I, CH_I, 8'h58};
    flush_file();
    file_buf = '{CH_M, CH_M};
    flush_file();
    file_buf = '{8'hFF};
    flush_file();
    file_buf = '{CH_PCT, 8'h00};
    flush_file();
    file_buf = '{CH_PCT, CH_BANG};
    flush_file();
    // epsf prefix cut at the third byte, then at the magic, then mid-header
    file_buf = '{CH_E_HI, CH_P_HI, CH_S_HI};
    flush_file();
    add_magic();
    flush_file();
    add_magic();
    file_buf.push_back(8'h00);
    file_buf.push_back(CH_CR);
    flush_file();
    counted = byte_q.size();

    while (counted < byte_q.size() + RANDOM_WORDS - (byte_q.size() - counted) &&
           counted < 30 + RANDOM_WORDS)
      add_random_file();
    total_words = byte_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (want_q.size() != 0) begin
      $display("%0d expected words never arrived", want_q.size());
      errors++;
    end

    $display("%0d input words in %0d files, %0d result words checked",
             words_taken, files_built, results_checked);
    $display("rejects seen: %0d tiff, %0d unknown start, %0d cut header; %0d errors",
             tiff_seen, bad_seen, trunc_seen, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
